@@ rtl/wlam_pkg.sv @@
// shared types and constants for the window limit alarm monitor
// no dependencies; imported by wlam_cfg, wlam_step and the top level

package wlam_pkg;

	// register indexes of the configuration port
	localparam int unsigned CfgIdxW = 4;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_CHANNEL_KIND  = 4'd0;
	localparam logic [CfgIdxW-1:0] REG_ENABLE_PUSH   = 4'd1;
	localparam logic [CfgIdxW-1:0] REG_ENABLE_OUTPUT = 4'd2;
	localparam logic [CfgIdxW-1:0] REG_POLARITY_HIGH = 4'd3;
	localparam logic [CfgIdxW-1:0] REG_PIN_INDEX     = 4'd4;
	localparam logic [CfgIdxW-1:0] REG_UPPER_LIMIT   = 4'd5;
	localparam logic [CfgIdxW-1:0] REG_LOWER_LIMIT   = 4'd6;
	localparam logic [CfgIdxW-1:0] REG_ALARM_LEVEL   = 4'd7;

	// event codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_HIGH  = 2'd1;
	localparam logic [1:0] EV_LOW   = 2'd2;
	localparam logic [1:0] EV_CLEAR = 2'd3;

	// persistence counter landmarks
	localparam logic [7:0] CNT_NEUTRAL   = 8'd128;
	localparam logic [7:0] CNT_MAX       = 8'd254;
	localparam logic [7:0] CNT_TOP       = 8'd255;
	localparam logic [7:0] CNT_HIGH_1    = 8'd130;
	localparam logic [7:0] CNT_HIGH_2    = 8'd140;
	localparam logic [7:0] CNT_LOW_1     = 8'd126;
	localparam logic [7:0] CNT_LOW_2     = 8'd116;
	localparam logic [7:0] CNT_ALARM_1   = 8'd1;
	localparam logic [7:0] CNT_ALARM_2   = 8'd10;
	localparam logic [7:0] CNT_ZERO      = 8'd0;

	typedef struct packed {
		logic        channel_kind;
		logic        enable_push;
		logic        enable_output;
		logic        polarity_high;
		logic [5:0]  pin_index;
		logic [15:0] upper_limit;
		logic [15:0] lower_limit;
		logic        alarm_level;
	} cfg_t;

	typedef struct packed {
		logic [1:0] event_code;
		logic       push_request;
		logic       drive_valid;
		logic       drive_level;
		logic [5:0] drive_port;
	} result_t;

endpackage

@@ rtl/wlam_if.sv @@
// valid/ready channel interfaces for samples and results
// no dependencies

interface wlam_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample_value;
	logic        digital_level;

	modport source (output valid, sample_value, digital_level, input ready);
	modport sink (input valid, sample_value, digital_level, output ready);
endinterface

interface wlam_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_code;
	logic       push_request;
	logic       drive_valid;
	logic       drive_level;
	logic [5:0] drive_port;

	modport source (output valid, event_code, push_request, drive_valid, drive_level,
		drive_port, input ready);
	modport sink (input valid, event_code, push_request, drive_valid, drive_level,
		drive_port, output ready);
endinterface

@@ rtl/wlam_cfg.sv @@
// configuration register file of the monitor
// depends on wlam_pkg

module wlam_cfg
	import wlam_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANNEL_KIND:  cfg_q.channel_kind  <= cfg_data[0];
				REG_ENABLE_PUSH:   cfg_q.enable_push   <= cfg_data[0];
				REG_ENABLE_OUTPUT: cfg_q.enable_output <= cfg_data[0];
				REG_POLARITY_HIGH: cfg_q.polarity_high <= cfg_data[0];
				REG_PIN_INDEX:     cfg_q.pin_index     <= cfg_data[5:0];
				REG_UPPER_LIMIT:   cfg_q.upper_limit   <= cfg_data;
				REG_LOWER_LIMIT:   cfg_q.lower_limit   <= cfg_data;
				REG_ALARM_LEVEL:   cfg_q.alarm_level   <= cfg_data[0];
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/wlam_step.sv @@
// persistence counter and per-item event decision
// depends on wlam_pkg

module wlam_step
	import wlam_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  cfg_t        cfg,
	input  logic [15:0] sample_value,
	input  logic        digital_level,
	output result_t     res,
	output logic [7:0]  count
);

	logic [7:0] count_q;
	logic [7:0] count_nxt;
	logic [7:0] inc;
	logic [7:0] dec;
	logic [1:0] ev;
	logic       enabled;
	logic       sense;
	logic       hi;
	logic       lo;
	logic       set_pin;

	assign enabled = cfg.enable_push | cfg.enable_output;
	assign sense   = cfg.upper_limit > cfg.lower_limit;
	assign hi      = sense ? (sample_value > cfg.upper_limit) : (sample_value < cfg.upper_limit);
	assign lo      = sense ? (sample_value < cfg.lower_limit) : (sample_value > cfg.lower_limit);

	// saturating steps, wrap first then clamp
	always_comb begin
		inc = count_q + 8'd1;
		if (inc == CNT_TOP) begin
			inc = CNT_MAX;
		end
		dec = count_q - 8'd1;
		if (dec == CNT_ZERO) begin
			dec = CNT_ALARM_1;
		end
	end

	always_comb begin
		ev        = EV_NONE;
		count_nxt = count_q;
		if (!enabled) begin
			count_nxt = cfg.channel_kind ? CNT_ZERO : CNT_NEUTRAL;
		end else if (cfg.channel_kind) begin
			if (digital_level == cfg.alarm_level) begin
				count_nxt = inc;
				if (inc == CNT_ALARM_1 || inc == CNT_ALARM_2) begin
					ev = EV_HIGH;
				end
			end else begin
				count_nxt = CNT_ZERO;
				if (count_q > CNT_ALARM_1) begin
					ev = EV_CLEAR;
				end
			end
		end else if (hi) begin
			if (count_q < CNT_NEUTRAL) begin
				count_nxt = CNT_NEUTRAL;
				ev        = EV_CLEAR;
			end else begin
				count_nxt = inc;
				if (inc == CNT_HIGH_1 || inc == CNT_HIGH_2) begin
					ev = EV_HIGH;
				end
			end
		end else if (lo) begin
			if (count_q > CNT_NEUTRAL) begin
				count_nxt = CNT_NEUTRAL;
				ev        = EV_CLEAR;
			end else begin
				count_nxt = dec;
				if (dec == CNT_LOW_1 || dec == CNT_LOW_2) begin
					ev = EV_LOW;
				end
			end
		end else begin
			count_nxt = CNT_NEUTRAL;
			if (count_q < CNT_LOW_1 || count_q > CNT_HIGH_1) begin
				ev = EV_CLEAR;
			end
		end
	end

	// pin set condition depends on mode and polarity
	assign set_pin = cfg.channel_kind ? (ev == EV_HIGH)
		: ((ev == EV_LOW && !cfg.polarity_high) || (ev == EV_HIGH && cfg.polarity_high));

	always_comb begin
		res.event_code   = ev;
		res.push_request = cfg.enable_push
			& ((ev == EV_HIGH) | (!cfg.channel_kind & (ev == EV_LOW)));
		res.drive_valid  = cfg.enable_output & (set_pin | (ev == EV_CLEAR));
		res.drive_level  = cfg.enable_output & set_pin;
		res.drive_port   = res.drive_valid ? cfg.pin_index : 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_NEUTRAL;
		end else if (advance) begin
			count_q <= count_nxt;
		end
	end

	assign count = count_q;

endmodule

@@ rtl/window_limit_alarm_monitor_core.sv @@
// top level of the window limit alarm monitor
// depends on wlam_pkg, wlam_if, wlam_cfg and wlam_step
//
//  channel    dir  handshake     payload
//  sample_ch  in   valid/ready   sample_value[15:0], digital_level
//  result_ch  out  valid/ready   event_code[1:0], push_request, drive_valid,
//                                drive_level, drive_port[5:0]
//  cfg_*      in   cfg_we only   cfg_index[3:0], cfg_data[15:0]
//
// every item gives exactly one result; one item per clock is sustained while result_ch is ready
// an item passes through the input register, then the step logic into the result register
// the persistence counter moves in the same cycle an item leaves the input register,
// so the next item already sees the updated count
// a stalled result holds the result register and then the input register; sample_ch.ready
// falls only when both are full
// reset clears the valid flags, the configuration and sets the counter to neutral (128)

module window_limit_alarm_monitor_core
	import wlam_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	wlam_sample_if.sink         sample_ch,
	wlam_result_if.source       result_ch,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t        cfg;
	result_t     res;
	result_t     res_q;
	logic [7:0]  count;

	// input register
	logic        valid_s1;
	logic [15:0] sample_s1;
	logic        level_s1;

	// result register
	logic        out_valid_q;

	logic        advance;   // item moves from input register to result register
	logic        take;      // new item enters the input register

	assign advance = valid_s1 & (~out_valid_q | result_ch.ready);
	assign take    = sample_ch.valid & sample_ch.ready;
	assign sample_ch.ready = ~valid_s1 | advance;

	wlam_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wlam_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.cfg           (cfg),
		.sample_value  (sample_s1),
		.digital_level (level_s1),
		.res           (res),
		.count         (count)
	);

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= sample_ch.sample_value;
			level_s1  <= sample_ch.digital_level;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.event_code   = res_q.event_code;
	assign result_ch.push_request = res_q.push_request;
	assign result_ch.drive_valid  = res_q.drive_valid;
	assign result_ch.drive_level  = res_q.drive_level;
	assign result_ch.drive_port   = res_q.drive_port;

	// a push only ever follows a high/alarm or low event
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.push_request) |->
			(res_q.event_code == EV_HIGH || res_q.event_code == EV_LOW))
		else $error("push request without high or low event");

	// a nonzero pin index is only shown with a drive command
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.drive_port != 6'd0) |-> res_q.drive_valid)
		else $error("drive port set without drive command");

	// with checking off, the counter falls back to its resting value
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !cfg.enable_push && !cfg.enable_output) |=>
			(count == ($past(cfg.channel_kind) ? CNT_ZERO : CNT_NEUTRAL)))
		else $error("counter not at rest while checking disabled");

	// an item leaving the input register always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result lost after step");

endmodule
